// ===== rtl/bft_pkg.sv =====
// ----------------------------------------------------------------------------
// bft_pkg
// Shared widths, reset values and controller/datapath interface types for
// the beacon freshness table.
// ----------------------------------------------------------------------------
`default_nettype none

package bft_pkg;

  // field widths
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned SLOT_W  = 3;

  // table geometry defaults
  localparam int unsigned TABLE_ENTRIES_DEF = 8;

  // freshness window after reset, in microseconds
  localparam logic [TIME_W-1:0] WINDOW_RESET_US = 64'd3_000_000;

  // commands from controller to datapath
  typedef struct packed {
    logic load;   // capture a new transaction, reset the read pointer and clear the match flag
    logic scan;   // issue one table read and advance the read pointer
    logic fin;    // commit the table update and register the result
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic last_rd;  // read pointer sits on the last entry
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/bft_ram.sv =====
// ----------------------------------------------------------------------------
// bft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bft_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bft_ctrl.sv =====
// ----------------------------------------------------------------------------
// bft_ctrl
// Sequencer for the beacon freshness table: accepts a transaction, walks the
// table once, then commits the update and issues the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module bft_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  output bft_pkg::cmd_t      cmd,
  input  wire bft_pkg::sts_t sts
);

  import bft_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.last_rd) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // command decode
  assign busy     = (state_r != S_IDLE);
  assign cmd.load = start && (state_r == S_IDLE);
  assign cmd.scan = (state_r == S_SCAN);
  assign cmd.fin  = (state_r == S_FIN);

  // an accepted transaction always enters the table walk
  a_load_scans: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_SCAN))
    else $error("accepted transaction did not start the table walk");

  // commit is a single cycle and frees the block
  a_fin_frees: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> !busy)
    else $error("block still busy after commit");

  // a walk ends only on the last entry
  a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && !sts.last_rd |=> (state_r == S_SCAN))
    else $error("table walk ended early");

endmodule

`default_nettype wire

// ===== rtl/bft_dp.sv =====
// ----------------------------------------------------------------------------
// bft_dp
// Datapath of the beacon freshness table: entry RAM with valid bits, match
// and oldest-entry search, per-entry staleness, update and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bft_dp #(
  parameter int unsigned TABLE_ENTRIES = bft_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bft_pkg::cmd_t               cmd,
  output bft_pkg::sts_t                    sts,
  input  wire logic [bft_pkg::TIME_W-1:0]  in_now_us,
  input  wire logic                        in_has_sample,
  input  wire logic                        in_rejected,
  input  wire logic [bft_pkg::ID_W-1:0]    in_beacon_id,
  input  wire logic                        cfg_we,
  input  wire logic [bft_pkg::TIME_W-1:0]  cfg_window,
  output logic                             out_valid,
  output logic                             out_healthy,
  output logic                             out_hit,
  output logic      [bft_pkg::SLOT_W-1:0]  out_slot_written
);

  import bft_pkg::*;

  localparam int unsigned N      = TABLE_ENTRIES;
  localparam int unsigned IDX_W  = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned WORD_W = ID_W + TIME_W;

  // transaction capture
  logic [TIME_W-1:0] now_r;
  logic [ID_W-1:0]   id_r;
  logic              wr_req_r;
  logic [TIME_W-1:0] window_r;

  // read pointer and read-data tracking
  logic [IDX_W-1:0]  rd_cnt_r;
  logic              chk_vld_r;
  logic [IDX_W-1:0]  chk_idx_r;

  // scan results
  logic              match_found_r;
  logic [IDX_W-1:0]  match_idx_r;
  logic [IDX_W-1:0]  oldest_idx_r;
  logic [TIME_W-1:0] oldest_time_r;
  logic [N-1:0]      stale_r;
  logic [N-1:0]      entry_vld_r;

  // result registers
  logic              out_valid_r;
  logic              out_healthy_r;
  logic              out_hit_r;
  logic [SLOT_W-1:0] out_slot_r;

  // ram and decoded entry
  logic [WORD_W-1:0] rd_word;
  logic [ID_W-1:0]   eff_id;
  logic [TIME_W-1:0] eff_time;
  logic [TIME_W-1:0] age;
  logic              ram_we;
  logic [IDX_W-1:0]  wr_idx;
  logic [N-1:0]      wr_mask;
  logic              healthy;

  bft_ram #(
    .WIDTH (WORD_W),
    .DEPTH (N)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata ({id_r, now_r}),
    .re    (cmd.scan),
    .raddr (rd_cnt_r),
    .rdata (rd_word)
  );

  // entries never written read as id 0, time 0
  always_comb begin
    if (entry_vld_r[chk_idx_r]) begin
      eff_id   = rd_word[WORD_W-1:TIME_W];
      eff_time = rd_word[TIME_W-1:0];
    end else begin
      eff_id   = '0;
      eff_time = '0;
    end
  end

  // wrapping age of the entry under test
  assign age = now_r - eff_time;

  // update target: first match, else oldest entry
  assign wr_idx = match_found_r ? match_idx_r : oldest_idx_r;
  assign ram_we = cmd.fin && wr_req_r;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      wr_mask[k] = wr_req_r && (wr_idx == IDX_W'(k));
    end
  end

  // the written entry has age zero, fresh unless the window is zero
  assign healthy = ~|(stale_r & ~wr_mask) && (!wr_req_r || (window_r != '0));

  assign sts.last_rd = (rd_cnt_r == IDX_W'(N - 1));

  // freshness window register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET_US;
    end else if (cfg_we) begin
      window_r <= cfg_window;
    end
  end

  // transaction capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r    <= in_now_us;
      id_r     <= in_beacon_id;
      wr_req_r <= in_has_sample && !in_rejected;
    end
  end

  // read pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_cnt_r <= '0;
    end else if (cmd.scan) begin
      rd_cnt_r <= rd_cnt_r + IDX_W'(1);
    end
  end

  // read data qualifier, valid in the cycle after the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r <= 1'b0;
    end else begin
      chk_vld_r <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= rd_cnt_r;
  end

  // match and oldest search, staleness per entry
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      match_found_r <= 1'b0;
    end else if (chk_vld_r) begin
      if (!match_found_r && (eff_id == id_r)) begin
        match_found_r <= 1'b1;
        match_idx_r   <= chk_idx_r;
      end
      if ((chk_idx_r == '0) || (eff_time < oldest_time_r)) begin
        oldest_idx_r  <= chk_idx_r;
        oldest_time_r <= eff_time;
      end
      stale_r[chk_idx_r] <= (age >= window_r);
    end
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= '0;
    end else if (ram_we) begin
      entry_vld_r <= entry_vld_r | wr_mask;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_healthy_r <= healthy;
      out_hit_r     <= wr_req_r && match_found_r;
      out_slot_r    <= wr_req_r ? SLOT_W'(wr_idx) : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_healthy      = out_healthy_r;
  assign out_hit          = out_hit_r;
  assign out_slot_written = out_slot_r;

  // result strobe follows a commit only
  a_strobe_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.fin))
    else $error("result strobe without commit");

  // every read returns data the cycle after it is issued
  a_chk_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |=> chk_vld_r)
    else $error("read data not qualified after table read");

  // a written entry is marked valid; valid bits clear only at reset
  a_vld_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (entry_vld_r & $past(wr_mask)) == $past(wr_mask))
    else $error("written entry not marked valid");

endmodule

`default_nettype wire

// ===== rtl/beacon_freshness_table_top.sv =====
// ----------------------------------------------------------------------------
// beacon_freshness_table_top
// Fully associative table of beacon ids and last-seen times with a health
// flag that reports whether every entry is within the freshness window.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions are taken at a rising edge with start high and busy
//   low; in_now_us, in_has_sample, in_rejected and in_beacon_id are sampled
//   there. A sample with in_has_sample high and in_rejected low refreshes the
//   first entry with a matching id, or else replaces the oldest entry.
//   Each transaction produces one result, shown for exactly one cycle with
//   out_valid high: out_healthy, out_hit and out_slot_written.
//   After the accepting edge the block walks the table (scan), drains the
//   last read, commits (fin) and registers the result. The walk reads one
//   entry per cycle from the single read port of the entry RAM, and busy
//   stays high until the commit is done, so transactions do not overlap.
//   The freshness window is written through cfg_valid/cfg_ready; cfg_ready
//   is high whenever busy is low.
//   Reset clears every entry to id 0 and time 0 (by valid bits, no clearing
//   pass) and loads the window with 3000000 us. The result channel has no
//   back-pressure; the receiver must take every strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module beacon_freshness_table_top #(
  parameter int unsigned TABLE_ENTRIES = bft_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input transaction
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [bft_pkg::TIME_W-1:0]  in_now_us,
  input  wire logic                        in_has_sample,
  input  wire logic                        in_rejected,
  input  wire logic [bft_pkg::ID_W-1:0]    in_beacon_id,
  // result
  output logic                             out_valid,
  output logic                             out_healthy,
  output logic                             out_hit,
  output logic      [bft_pkg::SLOT_W-1:0]  out_slot_written,
  // configuration
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [bft_pkg::TIME_W-1:0]  cfg_freshness_window_us
);

  import bft_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // configuration is taken while idle
  assign cfg_ready = !busy;

  bft_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  bft_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_now_us        (in_now_us),
    .in_has_sample    (in_has_sample),
    .in_rejected      (in_rejected),
    .in_beacon_id     (in_beacon_id),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_window       (cfg_freshness_window_us),
    .out_valid        (out_valid),
    .out_healthy      (out_healthy),
    .out_hit          (out_hit),
    .out_slot_written (out_slot_written)
  );

endmodule

`default_nettype wire

// ===== tb/tb_beacon_freshness_table_top.sv =====
// ----------------------------------------------------------------------------
// tb_beacon_freshness_table_top
// Self-checking bench for the beacon freshness table. A directed table walks
// the reset state, id zero hits, duplicate ids, rejected samples, extreme and
// backwards times. Random phases follow under several freshness windows (zero
// and all ones among them). Each transaction is mirrored in a local model of
// the table, and every result strobe is checked against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_beacon_freshness_table_top;

  import bft_pkg::*;

  localparam int unsigned NUM_ENTRIES   = TABLE_ENTRIES_DEF;
  localparam int unsigned SETTLE_CYCLES = NUM_ENTRIES + 3;
  localparam int unsigned PHASE_ITEMS   = 200;
  localparam int unsigned NUM_PHASES    = 6;
  localparam int unsigned ID_POOL_SIZE  = 12;

  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic              has_sample;
    logic              rejected;
    logic [ID_W-1:0]   beacon_id;
  } beacon_item_t;

  typedef struct packed {
    logic              healthy;
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } freshness_t;

  typedef struct {
    beacon_item_t item;
    bit           typed;
    freshness_t   res;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [TIME_W-1:0]   in_now_us;
  logic                in_has_sample;
  logic                in_rejected;
  logic [ID_W-1:0]     in_beacon_id;
  logic                out_valid;
  logic                out_healthy;
  logic                out_hit;
  logic [SLOT_W-1:0]   out_slot_written;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [TIME_W-1:0]   cfg_freshness_window_us;

  // local copy of the table and the window
  logic [ID_W-1:0]     tbl_id   [NUM_ENTRIES];
  logic [TIME_W-1:0]   tbl_time [NUM_ENTRIES];
  logic [TIME_W-1:0]   window_model;

  freshness_t          pending_results[$];
  stim_row_t           directed_rows[$];
  logic [ID_W-1:0]     id_pool[ID_POOL_SIZE];
  logic [TIME_W-1:0]   phase_window[NUM_PHASES];

  int unsigned         mismatch_count = 0;
  int unsigned         items_sent     = 0;
  int unsigned         results_seen   = 0;
  int unsigned         hits_seen      = 0;
  int unsigned         stale_seen     = 0;
  bit                  no_idle        = 1'b0;

  beacon_freshness_table_top u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .in_now_us               (in_now_us),
    .in_has_sample           (in_has_sample),
    .in_rejected             (in_rejected),
    .in_beacon_id            (in_beacon_id),
    .out_valid               (out_valid),
    .out_healthy             (out_healthy),
    .out_hit                 (out_hit),
    .out_slot_written        (out_slot_written),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_freshness_window_us (cfg_freshness_window_us)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // table update and health flag for one transaction
  function automatic freshness_t table_update(input beacon_item_t it);
    freshness_t        r;
    int unsigned       oldest;
    logic [TIME_W-1:0] oldest_time;
    logic              found;
    r = '0;
    if (it.has_sample && !it.rejected) begin
      found       = 1'b0;
      oldest      = 0;
      oldest_time = tbl_time[0];
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (!found) begin
          if (tbl_id[i] == it.beacon_id) begin
            tbl_time[i] = it.now;
            r.hit       = 1'b1;
            r.slot      = SLOT_W'(i);
            found       = 1'b1;
          end else if (tbl_time[i] < oldest_time) begin
            oldest      = i;
            oldest_time = tbl_time[i];
          end
        end
      end
      if (!found) begin
        tbl_id[oldest]   = it.beacon_id;
        tbl_time[oldest] = it.now;
        r.slot           = SLOT_W'(oldest);
      end
    end
    r.healthy = 1'b1;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (TIME_W'(it.now - tbl_time[i]) >= window_model) r.healthy = 1'b0;
    end
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic add_row(input logic [TIME_W-1:0] now, input logic has_sample,
                         input logic rejected, input logic [ID_W-1:0] id,
                         input bit typed, input logic healthy, input logic hit,
                         input logic [SLOT_W-1:0] slot);
    stim_row_t row;
    row.item  = '{now: now, has_sample: has_sample, rejected: rejected, beacon_id: id};
    row.typed = typed;
    row.res   = '{healthy: healthy, hit: hit, slot: slot};
    directed_rows.push_back(row);
  endtask

  // one input transaction, with an optional random gap before it
  task automatic send_item(input beacon_item_t it, input bit use_typed,
                           input freshness_t typed_res);
    freshness_t predicted;
    int unsigned gap;
    if (!no_idle && $urandom_range(0, 99) < 8) begin
      gap = $urandom_range(1, 14);
      repeat (gap) begin
        start         <= 1'b0;
        in_now_us     <= rand64();
        in_has_sample <= 1'($urandom_range(0, 1));
        in_rejected   <= 1'($urandom_range(0, 1));
        in_beacon_id  <= $urandom();
        @(posedge clk);
      end
    end
    start         <= 1'b1;
    in_now_us     <= it.now;
    in_has_sample <= it.has_sample;
    in_rejected   <= it.rejected;
    in_beacon_id  <= it.beacon_id;
    do @(posedge clk); while (busy);
    predicted = table_update(it);
    pending_results.push_back(use_typed ? typed_res : predicted);
    items_sent++;
  endtask

  // window write, only once the block has drained
  task automatic write_window(input logic [TIME_W-1:0] w);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid               <= 1'b1;
    cfg_freshness_window_us <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid               <= 1'b0;
    cfg_freshness_window_us <= rand64();
    window_model = w;
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    freshness_t exp_r;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_hit) hits_seen++;
      if (!out_healthy) stale_seen++;
      if (pending_results.size() == 0) begin
        log_mismatch($sformatf("result with nothing pending: healthy=%0b hit=%0b slot=%0d",
                               out_healthy, out_hit, out_slot_written));
      end else begin
        exp_r = pending_results.pop_front();
        if (out_healthy !== exp_r.healthy)
          log_mismatch($sformatf("healthy exp %0b got %0b", exp_r.healthy, out_healthy));
        if (out_hit !== exp_r.hit)
          log_mismatch($sformatf("hit exp %0b got %0b", exp_r.hit, out_hit));
        if (out_slot_written !== exp_r.slot)
          log_mismatch($sformatf("slot_written exp %0d got %0d", exp_r.slot,
                                 out_slot_written));
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    beacon_item_t      it;
    logic [TIME_W-1:0] now_t;
    int unsigned       step_cap;
    int unsigned       r;
    int unsigned       drain;

    rst_n                   <= 1'b0;
    start                   <= 1'b0;
    in_now_us               <= '0;
    in_has_sample           <= 1'b0;
    in_rejected             <= 1'b0;
    in_beacon_id            <= '0;
    cfg_valid               <= 1'b0;
    cfg_freshness_window_us <= '0;

    for (int i = 0; i < NUM_ENTRIES; i++) begin
      tbl_id[i]   = '0;
      tbl_time[i] = '0;
    end
    window_model = WINDOW_RESET_US;

    // reset, then release
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows under the reset window
    add_row(64'd0, 1'b0, 1'b0, 32'd0, 1, 1'b1, 1'b0, 3'd0);           // query after reset
    add_row(64'd0, 1'b1, 1'b0, 32'd0, 1, 1'b1, 1'b1, 3'd0);           // id zero hits entry 0
    add_row(64'd100, 1'b1, 1'b1, 32'h1234, 1, 1'b1, 1'b0, 3'd0);      // rejected sample
    add_row(WINDOW_RESET_US, 1'b0, 1'b0, 32'd0, 1, 1'b0, 1'b0, 3'd0); // age equals window
    add_row(WINDOW_RESET_US - 1, 1'b0, 1'b0, 32'd0, 1, 1'b1, 1'b0, 3'd0);
    add_row(64'd10, 1'b1, 1'b0, 32'hFFFF_FFFF, 0, 0, 0, 0);           // replaces entry 0
    add_row(64'd20, 1'b1, 1'b0, 32'd0, 0, 0, 0, 0);                   // duplicate ids
    for (int k = 0; k < 6; k++)
      add_row(64'd30 + 64'(10 * k), 1'b1, 1'b0, 32'h11 + 32'(k), 0, 0, 0, 0); // fill the table
    add_row(64'd90, 1'b1, 1'b0, 32'h77, 0, 0, 0, 0);                  // evict oldest
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 32'hA5A5_A5A5, 0, 0, 0, 0);
    add_row(64'd5, 1'b0, 1'b0, 32'd0, 0, 0, 0, 0);                    // time going back
    add_row(64'h8000_0000_0000_0000, 1'b1, 1'b1, 32'h5A5A_5A5A, 1, 1'b0, 1'b0, 3'd0);
    add_row(64'd200, 1'b0, 1'b1, 32'hFFFF_FFFF, 0, 0, 0, 0);          // query, rejected set
    add_row(64'd210, 1'b1, 1'b0, 32'hFFFF_FFFF, 0, 0, 0, 0);          // id evicted earlier, replaces oldest
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 32'd0, 0, 0, 0, 0);

    foreach (directed_rows[k])
      send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].res);

    // id pool, larger than the table so both hits and evictions occur
    id_pool[0] = 32'd0;
    id_pool[1] = 32'hFFFF_FFFF;
    for (int k = 2; k < ID_POOL_SIZE; k++) id_pool[k] = $urandom();

    phase_window[0] = '0;
    phase_window[1] = '1;
    phase_window[2] = 64'd1;
    phase_window[3] = WINDOW_RESET_US;
    phase_window[4] = rand64();
    phase_window[5] = 64'($urandom_range(1000, 32'h3FFF_FFFF));

    now_t = rand64() >> $urandom_range(8, 63);

    // random phases, one window setting each
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_window(phase_window[p]);
      if (window_model == 0 || window_model >= 64'h2_0000_0000) step_cap = 32'hFFFF_FFFF;
      else step_cap = 32'(window_model / 3) + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        no_idle = (items_sent >= 420 && items_sent < 620);
        r = $urandom_range(0, 99);
        if (r < 70)      now_t = now_t + 64'($urandom_range(0, step_cap));
        else if (r < 80) now_t = now_t;
        else if (r < 88) now_t = now_t - 64'($urandom_range(1, step_cap));
        else if (r < 95) now_t = rand64();
        else             now_t = $urandom_range(0, 1) ? '1 : '0;
        it.now        = now_t;
        it.has_sample = ($urandom_range(0, 99) < 85);
        it.rejected   = ($urandom_range(0, 99) < 15);
        r = $urandom_range(0, 99);
        if (r < 80)      it.beacon_id = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
        else if (r < 90) it.beacon_id = $urandom();
        else             it.beacon_id = '0;
        send_item(it, 1'b0, '0);
      end
    end

    // drain
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    drain = pending_results.size();
    if (drain != 0) log_mismatch($sformatf("%0d results never arrived", drain));

    $display("covered %0d transactions under %0d window settings plus the reset window",
             items_sent, NUM_PHASES);
    $display("checked %0d results: %0d table hits, %0d stale flags, %0d mismatches",
             results_seen, hits_seen, stale_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
